/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Condition c must hold in the cycle after a.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* rtl/mbrh_pkg.sv */
package mbrh_pkg;

	localparam int MAX_REGS_DEF = 32;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

	// Receive byte counter width; the counter wraps.
	localparam int CNT_W = 7;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	localparam logic [CFG_AW-1:0] CFG_SLAVE = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_START = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_COUNT = 2'd2;

	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_BYTE    = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [1:0] KIND_TX  = 2'd0;
	localparam logic [1:0] KIND_REG = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_TIMEOUT = 2'd1;
	localparam logic [1:0] STAT_CRC     = 2'd2;
	localparam logic [1:0] STAT_INVALID = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ERR,
		S_TX,
		S_TXCRC,
		S_RXCRC,
		S_RD,
		S_EMIT
	} fsm_state_t;

	typedef struct packed {
		logic init;
		logic start;
	} crc_ctrl_t;

endpackage

/* rtl/mbrh_if.sv */
interface mbrh_in_if import mbrh_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] rx_byte;

	modport source (output valid, command, rx_byte, input ready);
	modport sink (input valid, command, rx_byte, output ready);
endinterface

interface mbrh_out_if import mbrh_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic [4:0]  reg_index;
	logic [15:0] reg_value;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, kind, tx_byte, reg_index, reg_value, status, last,
		input ready);
	modport sink (input valid, kind, tx_byte, reg_index, reg_value, status, last,
		output ready);
endinterface

interface mbrh_cfg_if import mbrh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/mbrh_ram.sv */
module mbrh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/mbrh_crc.sv */
module mbrh_crc import mbrh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctrl_t   ctrl,
	input  logic [7:0]  data_in,
	output logic [15:0] crc,
	output logic        busy
);
	logic [15:0] crc_q;
	logic [3:0]  cnt_q;

	assign crc  = crc_q;
	assign busy = (cnt_q != 4'd0);

	// One bit of the reflected CRC per cycle after the byte is folded in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			cnt_q <= 4'd0;
		end else if (ctrl.init) begin
			crc_q <= CRC_INIT;
			cnt_q <= 4'd0;
		end else if (ctrl.start) begin
			crc_q <= crc_q ^ {8'h00, data_in};
			cnt_q <= 4'd8;
		end else if (busy) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			cnt_q <= cnt_q - 4'd1;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_NXT(a_start_busy, clk, arst_n, ctrl.start, busy)
	`ASSERT_IMP(a_cnt_range, clk, arst_n, busy, cnt_q <= 4'd8)
	`ASSERT_IMP(a_ctrl_excl, clk, arst_n, ctrl.init, !ctrl.start)
endmodule

/* rtl/modbus_rtu_read_holding_master.sv */
// Channel  Dir  Payload                                         Transfer
// cfg      in   addr (config register), data                     valid & ready
// req      in   command, rx_byte                                valid & ready
// rsp      out  kind, tx_byte, reg_index, reg_value, status, last valid & ready
//
// Every item is accepted in S_IDLE and decoded in S_EXEC. A received body
// byte then runs the bit-serial CRC unit, waited out in S_RXCRC; a send
// runs it six times over its 8 transfers, each transfer held while rsp stalls.
// A good response gives one register per S_RD and S_EMIT pass, bounded by the RAM read.
// Reset is asynchronous; afterwards the block is idle with config at its defaults.
// A stalled rsp only holds the block when a new result is ready to be loaded.
module modbus_rtu_read_holding_master import mbrh_pkg::*; #(
	parameter int MAX_REGS = MAX_REGS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mbrh_cfg_if.sink     cfg,
	mbrh_in_if.sink      req,
	mbrh_out_if.source   rsp
);
	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

	fsm_state_t state_q, state_d;

	logic [7:0]  slave_q;
	logic [15:0] start_q;
	logic [5:0]  count_q;

	logic [1:0]  cmd_q;
	logic [7:0]  byte_q;
	logic        phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]  crc_lo_q;
	logic        hdr_ok_q;
	logic [7:0]  hold_q;
	logic [7:0]  held_addr_q;
	logic [5:0]  held_cnt_q;
	logic [2:0]  tx_i_q;
	logic [CNT_W-1:0] rd_k_q;
	logic [1:0]  err_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_byte_q;
	logic [4:0]  reg_index_q;
	logic [15:0] reg_value_q;
	logic [1:0]  status_q;
	logic        last_q;

	crc_ctrl_t   crc_ctrl;
	logic [7:0]  crc_din;
	logic [15:0] crc_val;
	logic        crc_busy;

	logic        ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0] ram_rdata;

	logic        out_free, out_load;
	logic [1:0]  kind_d, status_d;
	logic [7:0]  tx_byte_d;
	logic [4:0]  reg_index_d;
	logic [15:0] reg_value_d;
	logic        last_d;

	logic [7:0]  exp_len;
	logic [7:0]  cnt_plus2;
	logic        count_bad, rx_body, rx_crc_lo, rx_final, crc_bad;
	logic [CNT_W-1:0] off;
	logic [CNT_W-1:0] idx;
	logic [7:0]  tx_sel;
	logic        rd_last;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid     = out_valid_q;
	assign rsp.kind      = kind_q;
	assign rsp.tx_byte   = tx_byte_q;
	assign rsp.reg_index = reg_index_q;
	assign rsp.reg_value = reg_value_q;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

	assign out_free = !out_valid_q || rsp.ready;

	// Response frame: address, function, byte count, 2*n data, CRC low, CRC high.
	assign exp_len   = 8'd5 + {1'b0, held_cnt_q, 1'b0};
	assign cnt_plus2 = {1'b0, cnt_q} + 8'd2;
	assign count_bad = (count_q == 6'd0) || ({1'b0, count_q} > 7'(MAX_REGS));
	assign rx_body   = phase_q && (cmd_q == CMD_BYTE) && (cnt_plus2 < exp_len);
	assign rx_crc_lo = phase_q && (cmd_q == CMD_BYTE) && (cnt_plus2 == exp_len);
	assign rx_final  = phase_q && (cmd_q == CMD_BYTE) && (cnt_plus2 > exp_len);
	assign crc_bad   = ({byte_q, crc_lo_q} != crc_val);
	assign off       = cnt_q - CNT_W'(3);
	assign idx       = {1'b0, off[CNT_W-1:1]};
	assign rd_last   = (rd_k_q == (CNT_W'(held_cnt_q) - CNT_W'(1)));

	always_comb begin
		case (tx_i_q)
			3'd0:    tx_sel = slave_q;
			3'd1:    tx_sel = FUNC_READ_HOLDING;
			3'd2:    tx_sel = start_q[15:8];
			3'd3:    tx_sel = start_q[7:0];
			3'd4:    tx_sel = 8'h00;
			3'd5:    tx_sel = {2'b00, count_q};
			3'd6:    tx_sel = crc_val[7:0];
			default: tx_sel = crc_val[15:8];
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd_q == CMD_SEND) begin
					state_d = count_bad ? S_ERR : S_TX;
				end else if (cmd_q == CMD_TIMEOUT && phase_q) begin
					state_d = S_ERR;
				end else if (rx_body) begin
					state_d = S_RXCRC;
				end else if (rx_final) begin
					state_d = (crc_bad || !hdr_ok_q) ? S_ERR : S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_TX: begin
				if (out_free) begin
					if (tx_i_q < 3'd6) begin
						state_d = S_TXCRC;
					end else if (tx_i_q == 3'd7) begin
						state_d = S_IDLE;
					end
				end
			end
			S_TXCRC: begin
				if (!crc_busy) begin
					state_d = S_TX;
				end
			end
			S_RXCRC: begin
				if (!crc_busy) begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = rd_last ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Strobes and result payload.
	always_comb begin
		crc_ctrl    = '0;
		crc_din     = byte_q;
		ram_we      = 1'b0;
		ram_waddr   = idx[AW-1:0];
		ram_re      = 1'b0;
		ram_raddr   = rd_k_q[AW-1:0];
		out_load    = 1'b0;
		kind_d      = KIND_TX;
		tx_byte_d   = 8'h00;
		reg_index_d = 5'd0;
		reg_value_d = 16'h0000;
		status_d    = STAT_OK;
		last_d      = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (cmd_q == CMD_SEND || (cmd_q == CMD_TIMEOUT && phase_q) || rx_final) begin
					crc_ctrl.init = 1'b1;
				end else if (rx_body) begin
					crc_ctrl.start = 1'b1;
					ram_we = (cnt_q >= CNT_W'(3)) && !cnt_q[0];
				end
			end
			S_ERR: begin
				out_load = out_free;
				kind_d   = KIND_ERR;
				status_d = err_q;
				last_d   = 1'b1;
			end
			S_TX: begin
				out_load  = out_free;
				tx_byte_d = tx_sel;
				last_d    = (tx_i_q == 3'd7);
				crc_din   = tx_sel;
				if (out_free) begin
					crc_ctrl.start = (tx_i_q < 3'd6);
					crc_ctrl.init  = (tx_i_q == 3'd7);
				end
			end
			S_RD: begin
				ram_re = 1'b1;
			end
			S_EMIT: begin
				out_load    = out_free;
				kind_d      = KIND_REG;
				reg_index_d = rd_k_q[4:0];
				reg_value_d = ram_rdata;
				last_d      = rd_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slave_q     <= 8'd1;
			start_q     <= 16'd0;
			count_q     <= 6'd1;
			phase_q     <= 1'b0;
			cnt_q       <= '0;
			crc_lo_q    <= 8'd0;
			hdr_ok_q    <= 1'b1;
			hold_q      <= 8'd0;
			tx_i_q      <= 3'd0;
			rd_k_q      <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				case (cfg.addr)
					CFG_SLAVE: slave_q <= cfg.data[7:0];
					CFG_START: start_q <= cfg.data;
					CFG_COUNT: count_q <= cfg.data[5:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_EXEC: begin
					if (cmd_q == CMD_SEND || (cmd_q == CMD_TIMEOUT && phase_q) || rx_final) begin
						phase_q  <= 1'b0;
						cnt_q    <= '0;
						crc_lo_q <= 8'd0;
						hdr_ok_q <= 1'b1;
						hold_q   <= 8'd0;
						tx_i_q   <= 3'd0;
						rd_k_q   <= '0;
					end
					if (cmd_q == CMD_SEND) begin
						err_q <= STAT_INVALID;
					end else if (cmd_q == CMD_TIMEOUT) begin
						err_q <= STAT_TIMEOUT;
					end else if (rx_final) begin
						err_q <= crc_bad ? STAT_CRC : STAT_INVALID;
					end
					if (rx_body) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if ((cnt_q == CNT_W'(0) && byte_q != held_addr_q) ||
							(cnt_q == CNT_W'(1) && byte_q != FUNC_READ_HOLDING) ||
							(cnt_q == CNT_W'(2) && byte_q != {1'b0, held_cnt_q, 1'b0})) begin
							hdr_ok_q <= 1'b0;
						end
						if (cnt_q >= CNT_W'(3) && cnt_q[0]) begin
							hold_q <= byte_q;
						end
					end
					if (rx_crc_lo) begin
						crc_lo_q <= byte_q;
						cnt_q    <= cnt_q + CNT_W'(1);
					end
				end
				S_TX: begin
					if (out_free) begin
						tx_i_q <= tx_i_q + 3'd1;
						if (tx_i_q == 3'd7) begin
							phase_q <= 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rd_k_q <= rd_k_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Items, request fields and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q  <= req.command;
			byte_q <= req.rx_byte;
		end
		if (state_q == S_EXEC && cmd_q == CMD_SEND) begin
			held_addr_q <= slave_q;
			held_cnt_q  <= count_q;
		end
		if (out_load) begin
			kind_q      <= kind_d;
			tx_byte_q   <= tx_byte_d;
			reg_index_q <= reg_index_d;
			reg_value_q <= reg_value_d;
			status_q    <= status_d;
			last_q      <= last_d;
		end
	end

	mbrh_crc u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (crc_ctrl),
		.data_in (crc_din),
		.crc     (crc_val),
		.busy    (crc_busy)
	);

	mbrh_ram #(
		.WIDTH (16),
		.DEPTH (MAX_REGS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({hold_q, byte_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`include "assert_macros.svh"

	`ASSERT_IMP(a_store_in_rx, clk, arst_n, ram_we, phase_q && (state_q == S_EXEC))
	`ASSERT_IMP(a_crc_idle_on_start, clk, arst_n, crc_ctrl.start, !crc_busy)
	`ASSERT_IMP(a_read_in_range, clk, arst_n, state_q == S_EMIT, rd_k_q < CNT_W'(held_cnt_q))
endmodule
